>>> rtl/core/dmbm_pkg.sv
`default_nettype none
package dmbm_pkg;

    localparam int DIM_BITS    = 12;
    localparam int PROD_W      = 2 * DIM_BITS;
    localparam int DIST_W      = DIM_BITS + 1;
    localparam int IDENT_W     = 32;
    localparam int DEPTH_W     = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SOURCE_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SOURCE_HEIGHT = t_cfg_idx'(1);
    localparam t_cfg_idx CFG_WANTED_DEPTH  = t_cfg_idx'(2);

    localparam logic [DIM_BITS-1:0] SOURCE_WIDTH_RST  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] SOURCE_HEIGHT_RST = DIM_BITS'(480);
    localparam logic [DEPTH_W-1:0]  WANTED_DEPTH_RST  = DEPTH_W'(16);

    // classified candidate, front to back
    typedef struct packed {
        logic                judged;
        logic                covers;
        logic                last;
        logic [IDENT_W-1:0]  ident;
        logic [DEPTH_W-1:0]  bits;
        logic [PROD_W-1:0]   aspect;
        logic [PROD_W-1:0]   excess;
        logic [DIST_W-1:0]   distance;
    } t_cand;

    typedef struct packed {
        logic                found;
        logic [IDENT_W-1:0]  ident;
        logic [DEPTH_W-1:0]  depth;
        logic                covers;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/core/display_mode_best_match.sv
// display_mode_best_match
// Picks the best screen mode for a video source from a stream of candidates.
// Input channel (i_valid/o_ready): one candidate per transaction; the one
// with i_last_candidate set closes the search. Only the closing transaction
// produces a result on the output channel (o_valid/i_ready): found flag,
// chosen identifier, its depth and whether it covers the source.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_index (0 source
// width, 1 source height, 2 wanted depth) on the same edge; write only while
// the block is idle.
// Throughput: one candidate per cycle while the queue has room. The front
// classifies a candidate in the cycle it is accepted (four 12x12 products in
// parallel) and pushes it into a 2-entry queue; the back pops one entry per
// cycle into the trackers, but holds a closing entry until the output
// register is free. The result of the closing entry is registered, once that
// entry heads the queue, in the output register that drives o_valid.
// Reset (synchronous, i_rst_n low) empties the queue, drops any result and
// restores defaults 640 x 480 x 16. If the receiver stalls, the result holds
// in the output register; the queue keeps taking candidates until it fills,
// then o_ready drops.
`default_nettype none
module display_mode_best_match (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [dmbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [dmbm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_candidate_ok,
    input  wire logic [dmbm_pkg::IDENT_W-1:0]         i_mode_ident,
    input  wire logic [dmbm_pkg::DIM_BITS-1:0]        i_mode_width,
    input  wire logic [dmbm_pkg::DIM_BITS-1:0]        i_mode_height,
    input  wire logic [dmbm_pkg::DEPTH_W-1:0]         i_mode_bits,
    input  wire logic                                 i_last_candidate,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic                                      o_found,
    output logic [dmbm_pkg::IDENT_W-1:0]              o_chosen_ident,
    output logic [dmbm_pkg::DEPTH_W-1:0]              o_chosen_depth,
    output logic                                      o_covers_source
);
    import dmbm_pkg::*;

    logic    push, can_push, q_valid, pop;
    t_cand   push_cand, q_cand;
    t_result result;

    dmbm_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (t_cfg_idx'(i_cfg_index)),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_candidate_ok   (i_candidate_ok),
        .i_mode_ident     (i_mode_ident),
        .i_mode_width     (i_mode_width),
        .i_mode_height    (i_mode_height),
        .i_mode_bits      (i_mode_bits),
        .i_last_candidate (i_last_candidate),
        .i_q_can_push     (can_push),
        .o_push           (push),
        .o_cand           (push_cand)
    );

    dmbm_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_data     (push_cand),
        .o_can_push (can_push),
        .o_valid    (q_valid),
        .o_data     (q_cand),
        .i_pop      (pop)
    );

    dmbm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_cand),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (result)
    );

    assign o_found         = result.found;
    assign o_chosen_ident  = result.ident;
    assign o_chosen_depth  = result.depth;
    assign o_covers_source = result.covers;

endmodule
`default_nettype wire

>>> rtl/core/dmbm_front.sv
`default_nettype none
module dmbm_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire dmbm_pkg::t_cfg_idx                   i_cfg_index,
    input  wire logic [dmbm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic                                 i_candidate_ok,
    input  wire logic [dmbm_pkg::IDENT_W-1:0]         i_mode_ident,
    input  wire logic [dmbm_pkg::DIM_BITS-1:0]        i_mode_width,
    input  wire logic [dmbm_pkg::DIM_BITS-1:0]        i_mode_height,
    input  wire logic [dmbm_pkg::DEPTH_W-1:0]         i_mode_bits,
    input  wire logic                                 i_last_candidate,
    input  wire logic                                 i_q_can_push,
    output logic                                      o_push,
    output dmbm_pkg::t_cand                           o_cand
);
    import dmbm_pkg::*;

    logic [DIM_BITS-1:0] r_src_w;
    logic [DIM_BITS-1:0] r_src_h;
    logic [DEPTH_W-1:0]  r_depth;

    logic [PROD_W-1:0]   p_wsh, p_hsw, p_wh, p_ss;
    logic [DIM_BITS-1:0] dw, dh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SOURCE_WIDTH_RST;
            r_src_h <= SOURCE_HEIGHT_RST;
            r_depth <= WANTED_DEPTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_WIDTH:  r_src_w <= i_cfg_data[DIM_BITS-1:0];
                CFG_SOURCE_HEIGHT: r_src_h <= i_cfg_data[DIM_BITS-1:0];
                CFG_WANTED_DEPTH:  r_depth <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        p_wsh = PROD_W'(i_mode_width) * PROD_W'(r_src_h);
        p_hsw = PROD_W'(i_mode_height) * PROD_W'(r_src_w);
        p_wh  = PROD_W'(i_mode_width) * PROD_W'(i_mode_height);
        p_ss  = PROD_W'(r_src_w) * PROD_W'(r_src_h);
        dw = (i_mode_width >= r_src_w) ? i_mode_width - r_src_w : r_src_w - i_mode_width;
        dh = (i_mode_height >= r_src_h) ? i_mode_height - r_src_h
                                        : r_src_h - i_mode_height;

        o_cand.judged   = i_candidate_ok && (i_mode_width != '0) && (i_mode_height != '0)
                          && (i_mode_bits == r_depth);
        o_cand.covers   = (i_mode_width >= r_src_w) && (i_mode_height >= r_src_h);
        o_cand.last     = i_last_candidate;
        o_cand.ident    = i_mode_ident;
        o_cand.bits     = i_mode_bits;
        o_cand.aspect   = (p_wsh >= p_hsw) ? p_wsh - p_hsw : p_hsw - p_wsh;
        o_cand.excess   = p_wh - p_ss;
        o_cand.distance = DIST_W'(dw) + DIST_W'(dh);
    end

    assign o_ready = i_q_can_push;
    assign o_push  = i_valid && i_q_can_push;

endmodule
`default_nettype wire

>>> rtl/core/dmbm_queue.sv
`default_nettype none
module dmbm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire dmbm_pkg::t_cand  i_data,
    output logic                  o_can_push,
    output logic                  o_valid,
    output dmbm_pkg::t_cand       o_data,
    input  wire logic             i_pop
);
    import dmbm_pkg::*;

    t_cand              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
        else                               r = p + 1'b1;
        return r;
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop)      n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_can_push = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

>>> rtl/core/dmbm_back.sv
`default_nettype none
module dmbm_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_q_valid,
    input  wire dmbm_pkg::t_cand  i_q_data,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output dmbm_pkg::t_result     o_result
);
    import dmbm_pkg::*;

    logic               r_fit_seen, n_fit_seen;
    logic [IDENT_W-1:0] r_fit_ident, n_fit_ident;
    logic [PROD_W-1:0]  r_fit_excess, n_fit_excess;
    logic [DIST_W-1:0]  r_fit_dist, n_fit_dist;
    logic [PROD_W-1:0]  r_fit_aspect, n_fit_aspect;
    logic [DEPTH_W-1:0] r_fit_bits, n_fit_bits;
    logic               r_oth_seen, n_oth_seen;
    logic [IDENT_W-1:0] r_oth_ident, n_oth_ident;
    logic [DIST_W-1:0]  r_oth_dist, n_oth_dist;
    logic [PROD_W-1:0]  r_oth_aspect, n_oth_aspect;
    logic [DEPTH_W-1:0] r_oth_bits, n_oth_bits;

    logic               r_out_valid;
    t_result            r_out, n_out;
    logic               out_free, fit_better, oth_better, emit;

    always_comb begin
        out_free = !r_out_valid || i_ready;
        o_pop    = i_q_valid && (!i_q_data.last || out_free);
        emit     = o_pop && i_q_data.last;

        fit_better = !r_fit_seen || (i_q_data.aspect < r_fit_aspect) ||
                     ((i_q_data.aspect == r_fit_aspect) &&
                      ((i_q_data.excess < r_fit_excess) ||
                       ((i_q_data.excess == r_fit_excess) &&
                        (i_q_data.distance < r_fit_dist))));
        oth_better = !r_oth_seen || (i_q_data.aspect < r_oth_aspect) ||
                     ((i_q_data.aspect == r_oth_aspect) &&
                      (i_q_data.distance < r_oth_dist));

        n_fit_seen   = r_fit_seen;
        n_fit_ident  = r_fit_ident;
        n_fit_excess = r_fit_excess;
        n_fit_dist   = r_fit_dist;
        n_fit_aspect = r_fit_aspect;
        n_fit_bits   = r_fit_bits;
        n_oth_seen   = r_oth_seen;
        n_oth_ident  = r_oth_ident;
        n_oth_dist   = r_oth_dist;
        n_oth_aspect = r_oth_aspect;
        n_oth_bits   = r_oth_bits;

        if (i_q_data.judged) begin
            if (i_q_data.covers) begin
                if (fit_better) begin
                    n_fit_seen   = 1'b1;
                    n_fit_ident  = i_q_data.ident;
                    n_fit_excess = i_q_data.excess;
                    n_fit_dist   = i_q_data.distance;
                    n_fit_aspect = i_q_data.aspect;
                    n_fit_bits   = i_q_data.bits;
                end
            end else if (oth_better) begin
                n_oth_seen   = 1'b1;
                n_oth_ident  = i_q_data.ident;
                n_oth_dist   = i_q_data.distance;
                n_oth_aspect = i_q_data.aspect;
                n_oth_bits   = i_q_data.bits;
            end
        end

        if (n_fit_seen) begin
            n_out = '{found: 1'b1, ident: n_fit_ident, depth: n_fit_bits, covers: 1'b1};
        end else if (n_oth_seen) begin
            n_out = '{found: 1'b1, ident: n_oth_ident, depth: n_oth_bits, covers: 1'b0};
        end else begin
            n_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || emit) begin
            r_fit_seen   <= 1'b0;
            r_fit_ident  <= '0;
            r_fit_excess <= '1;
            r_fit_dist   <= '1;
            r_fit_aspect <= '1;
            r_fit_bits   <= '0;
            r_oth_seen   <= 1'b0;
            r_oth_ident  <= '0;
            r_oth_dist   <= '1;
            r_oth_aspect <= '1;
            r_oth_bits   <= '0;
        end else if (o_pop) begin
            r_fit_seen   <= n_fit_seen;
            r_fit_ident  <= n_fit_ident;
            r_fit_excess <= n_fit_excess;
            r_fit_dist   <= n_fit_dist;
            r_fit_aspect <= n_fit_aspect;
            r_fit_bits   <= n_fit_bits;
            r_oth_seen   <= n_oth_seen;
            r_oth_ident  <= n_oth_ident;
            r_oth_dist   <= n_oth_dist;
            r_oth_aspect <= n_oth_aspect;
            r_oth_bits   <= n_oth_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> !r_fit_seen && !r_oth_seen)
        else $error("trackers not cleared after result");
    a_no_emit_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("result would overwrite pending transaction");
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |->
            (r_out.ident == '0) && (r_out.depth == '0) && !r_out.covers)
        else $error("empty result carries data");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_out_valid)
        else $error("result not presented");

endmodule
`default_nettype wire

>>> verif/display_mode_best_match_tb.sv
`timescale 1ns / 1ps
module display_mode_best_match_tb;
    import dmbm_pkg::*;

    typedef struct {
        logic                ok;
        logic [IDENT_W-1:0]  ident;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        logic [DEPTH_W-1:0]  bits;
        logic                last;
    } t_mode_offer;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_candidate_ok;
    logic [IDENT_W-1:0]    i_mode_ident;
    logic [DIM_BITS-1:0]   i_mode_width;
    logic [DIM_BITS-1:0]   i_mode_height;
    logic [DEPTH_W-1:0]    i_mode_bits;
    logic                  i_last_candidate;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_found;
    logic [IDENT_W-1:0]    o_chosen_ident;
    logic [DEPTH_W-1:0]    o_chosen_depth;
    logic                  o_covers_source;

    display_mode_best_match dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_candidate_ok   (i_candidate_ok),
        .i_mode_ident     (i_mode_ident),
        .i_mode_width     (i_mode_width),
        .i_mode_height    (i_mode_height),
        .i_mode_bits      (i_mode_bits),
        .i_last_candidate (i_last_candidate),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_found          (o_found),
        .o_chosen_ident   (o_chosen_ident),
        .o_chosen_depth   (o_chosen_depth),
        .o_covers_source  (o_covers_source)
    );

    always #2 i_clk = ~i_clk;

    // selector model state
    logic [DIM_BITS-1:0] src_w;
    logic [DIM_BITS-1:0] src_h;
    logic [DEPTH_W-1:0]  want_bits;

    logic                cover_seen;
    logic [IDENT_W-1:0]  cover_ident;
    logic [PROD_W-1:0]   cover_excess;
    logic [DIST_W-1:0]   cover_dist;
    logic [PROD_W-1:0]   cover_aspect;
    logic [DEPTH_W-1:0]  cover_bits;
    logic                near_seen;
    logic [IDENT_W-1:0]  near_ident;
    logic [DIST_W-1:0]   near_dist;
    logic [PROD_W-1:0]   near_aspect;
    logic [DEPTH_W-1:0]  near_bits;

    t_result pending_results[$];

    logic [DIM_BITS-1:0] prev_w;
    logic [DIM_BITS-1:0] prev_h;
    bit tx_gaps;
    bit rx_stalls;
    int offer_count;
    int search_count;
    int setting_count;
    int results_checked;
    int mismatch_count;

    function automatic void restart_search();
        cover_seen   = 1'b0;
        cover_ident  = '0;
        cover_excess = '1;
        cover_dist   = '1;
        cover_aspect = '1;
        cover_bits   = '0;
        near_seen    = 1'b0;
        near_ident   = '0;
        near_dist    = '1;
        near_aspect  = '1;
        near_bits    = '0;
    endfunction

    function automatic void rank_offer(input t_mode_offer m);
        logic [PROD_W-1:0] wsh;
        logic [PROD_W-1:0] hsw;
        logic [PROD_W-1:0] aspect;
        logic [PROD_W-1:0] excess;
        logic [DIST_W-1:0] dx;
        logic [DIST_W-1:0] dy;
        logic [DIST_W-1:0] dist_sum;
        if (!(m.ok && m.w != 0 && m.h != 0 && m.bits == want_bits))
            return;
        wsh      = m.w * src_h;
        hsw      = m.h * src_w;
        aspect   = (wsh >= hsw) ? wsh - hsw : hsw - wsh;
        dx       = (m.w >= src_w) ? m.w - src_w : src_w - m.w;
        dy       = (m.h >= src_h) ? m.h - src_h : src_h - m.h;
        dist_sum = dx + dy;
        if (m.w >= src_w && m.h >= src_h) begin
            excess = m.w * m.h - src_w * src_h;
            if (!cover_seen || aspect < cover_aspect ||
                (aspect == cover_aspect &&
                 (excess < cover_excess ||
                  (excess == cover_excess && dist_sum < cover_dist)))) begin
                cover_seen   = 1'b1;
                cover_ident  = m.ident;
                cover_excess = excess;
                cover_dist   = dist_sum;
                cover_aspect = aspect;
                cover_bits   = m.bits;
            end
        end else if (!near_seen || aspect < near_aspect ||
                     (aspect == near_aspect && dist_sum < near_dist)) begin
            near_seen   = 1'b1;
            near_ident  = m.ident;
            near_dist   = dist_sum;
            near_aspect = aspect;
            near_bits   = m.bits;
        end
    endfunction

    function automatic void predict_offer(input t_mode_offer m);
        t_result r;
        rank_offer(m);
        if (!m.last)
            return;
        r = '0;
        if (cover_seen) begin
            r.found  = 1'b1;
            r.ident  = cover_ident;
            r.depth  = cover_bits;
            r.covers = 1'b1;
        end else if (near_seen) begin
            r.found = 1'b1;
            r.ident = near_ident;
            r.depth = near_bits;
        end
        pending_results.push_back(r);
        restart_search();
    endfunction

    function automatic t_mode_offer offer(input logic ok, input logic [IDENT_W-1:0] ident,
                                          input int w, input int h, input int bits,
                                          input logic last);
        t_mode_offer m;
        m.ok    = ok;
        m.ident = ident;
        m.w     = DIM_BITS'(w);
        m.h     = DIM_BITS'(h);
        m.bits  = DEPTH_W'(bits);
        m.last  = last;
        return m;
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input int v);
        if (v < 1)
            return DIM_BITS'(1);
        if (v > 4095)
            return DIM_BITS'(4095);
        return DIM_BITS'(v);
    endfunction

    // mostly acceptable candidates clustered around the source size so that
    // ties and near misses on every ranking key are common
    function automatic t_mode_offer random_offer(input logic last);
        t_mode_offer m;
        int k;
        m.ok    = 1'b1;
        m.ident = $urandom;
        m.bits  = want_bits;
        m.last  = last;
        case ($urandom_range(0, 9))
            0: begin m.w = src_w; m.h = src_h; end
            1: begin
                m.w = clamp_dim(src_w + $urandom_range(0, 64));
                m.h = clamp_dim(src_h + $urandom_range(0, 64));
            end
            2: begin
                m.w = clamp_dim(int'(src_w) - int'($urandom_range(0, 64)));
                m.h = clamp_dim(int'(src_h) - int'($urandom_range(0, 64)));
            end
            3: begin
                m.w = DIM_BITS'($urandom_range(1, 4095));
                m.h = DIM_BITS'($urandom_range(1, 4095));
            end
            4: begin m.w = prev_w; m.h = prev_h; end
            5: begin
                if ($urandom_range(0, 1)) begin
                    m.w = clamp_dim(src_w / 2);
                    m.h = clamp_dim(src_h / 2);
                end else begin
                    m.w = clamp_dim(src_w * 2);
                    m.h = clamp_dim(src_h * 2);
                end
            end
            6: begin
                k = $urandom_range(0, 32);
                m.w = clamp_dim(src_w + k);
                m.h = clamp_dim(int'(src_h) - k);
            end
            7: begin
                m.w = DIM_BITS'($urandom_range(1, 64));
                m.h = DIM_BITS'($urandom_range(1, 64));
            end
            8: begin
                k = $urandom_range(1, 3);
                m.w = clamp_dim(src_w * k);
                m.h = clamp_dim(src_h * k);
            end
            default: begin
                m.w = clamp_dim(int'(src_w) + int'($urandom_range(0, 16)) - 8);
                m.h = DIM_BITS'($urandom_range(1, 4095));
            end
        endcase
        if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 3))
                0: m.ok = 1'b0;
                1: m.w = '0;
                2: m.h = '0;
                default: m.bits = DEPTH_W'($urandom_range(0, 32));
            endcase
        end
        if (m.w != 0 && m.h != 0) begin
            prev_w = m.w;
            prev_h = m.h;
        end
        return m;
    endfunction

    task automatic send_offer(input t_mode_offer m);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid          = 1'b1;
        i_candidate_ok   = m.ok;
        i_mode_ident     = m.ident;
        i_mode_width     = m.w;
        i_mode_height    = m.h;
        i_mode_bits      = m.bits;
        i_last_candidate = m.last;
        do @(posedge i_clk); while (!o_ready);
        predict_offer(m);
        offer_count++;
        if (m.last)
            search_count++;
    endtask

    task automatic await_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int w, input int h, input int d);
        await_idle();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = CFG_SOURCE_WIDTH;
        i_cfg_data  = CFG_DATA_W'(w);
        @(negedge i_clk);
        i_cfg_index = CFG_SOURCE_HEIGHT;
        i_cfg_data  = CFG_DATA_W'(h);
        @(negedge i_clk);
        i_cfg_index = CFG_WANTED_DEPTH;
        i_cfg_data  = CFG_DATA_W'(d);
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        src_w     = DIM_BITS'(w);
        src_h     = DIM_BITS'(h);
        want_bits = DEPTH_W'(d);
        setting_count++;
    endtask

    task automatic run_search(input int n);
        for (int i = 0; i < n; i++)
            send_offer(random_offer(i == n - 1));
    endtask

    // reset settings 640x480x16
    task automatic test_extremes_and_rejects();
        send_offer(offer(1'b1, 32'h0, 640, 480, 16, 1'b0));
        send_offer(offer(1'b1, 32'hFFFF_FFFF, 4095, 4095, 16, 1'b0));
        send_offer(offer(1'b1, 32'h5, 1, 1, 16, 1'b1));
        send_offer(offer(1'b1, 32'hFFFF_FFFF, 4095, 1, 16, 1'b0));
        send_offer(offer(1'b1, 32'h7, 1, 4095, 16, 1'b1));
        // nothing acceptable: off, zero sizes, wrong depths
        send_offer(offer(1'b0, 32'h11, 640, 480, 16, 1'b0));
        send_offer(offer(1'b1, 32'h12, 0, 480, 16, 1'b0));
        send_offer(offer(1'b1, 32'h13, 640, 0, 16, 1'b0));
        send_offer(offer(1'b1, 32'h14, 640, 480, 0, 1'b0));
        send_offer(offer(1'b1, 32'h15, 640, 480, 32, 1'b0));
        send_offer(offer(1'b0, 32'h16, 0, 0, 63, 1'b1));
    endtask

    task automatic test_last_item_judged();
        send_offer(offer(1'b1, 32'h21, 100, 100, 16, 1'b0));
        send_offer(offer(1'b1, 32'h22, 1280, 960, 16, 1'b1));
    endtask

    task automatic test_tie_breaks();
        send_offer(offer(1'b1, 32'hA, 800, 600, 16, 1'b0));
        send_offer(offer(1'b1, 32'hB, 800, 600, 16, 1'b1));
        send_offer(offer(1'b1, 32'hC, 1280, 960, 16, 1'b0));
        send_offer(offer(1'b1, 32'hD, 640, 480, 16, 1'b1));
        send_offer(offer(1'b1, 32'hE, 160, 120, 16, 1'b0));
        send_offer(offer(1'b1, 32'hF, 320, 240, 16, 1'b1));
    endtask

    // zero source: every nonzero mode covers, smallest area wins
    task automatic test_zero_source_size();
        apply_setting(0, 0, 32);
        send_offer(offer(1'b1, 32'h31, 5, 3, 32, 1'b0));
        send_offer(offer(1'b1, 32'h32, 1, 1, 16, 1'b0));
        send_offer(offer(1'b1, 32'h33, 2, 1, 32, 1'b1));
    endtask

    task automatic test_random_searches();
        int count;
        int n;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: apply_setting(4095, 4095, 32);
                1: apply_setting(1, 1, 1);
                2: apply_setting(1920, 1080, 24);
                3: apply_setting(640, 480, 31);
                default: apply_setting($urandom_range(1, 4095), $urandom_range(1, 4095),
                                       $urandom_range(1, 32));
            endcase
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            count = 0;
            while (count < 95) begin
                n = $urandom_range(1, 8);
                run_search(n);
                count += n;
            end
        end
    endtask

    task automatic test_unthrottled();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        apply_setting($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(1, 32));
        repeat (12) run_search($urandom_range(1, 8));
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with none pending: ident 0x%0h", o_chosen_ident);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("found", 32'(want.found), 32'(o_found));
                check_field("chosen_ident", want.ident, o_chosen_ident);
                check_field("chosen_depth", 32'(want.depth), 32'(o_chosen_depth));
                check_field("covers_source", 32'(want.covers), 32'(o_covers_source));
            end
            results_checked++;
        end
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_stalls && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                repeat ($urandom_range(1, 15) - 1) @(negedge i_clk);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("display_mode_best_match regression: fail");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_SOURCE_WIDTH;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_candidate_ok   = 1'b0;
        i_mode_ident     = '0;
        i_mode_width     = '0;
        i_mode_height    = '0;
        i_mode_bits      = '0;
        i_last_candidate = 1'b0;
        src_w            = SOURCE_WIDTH_RST;
        src_h            = SOURCE_HEIGHT_RST;
        want_bits        = WANTED_DEPTH_RST;
        prev_w           = SOURCE_WIDTH_RST;
        prev_h           = SOURCE_HEIGHT_RST;
        tx_gaps          = 1'b1;
        rx_stalls        = 1'b1;
        restart_search();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_extremes_and_rejects();
        test_last_item_judged();
        test_tie_breaks();
        test_zero_source_size();
        test_random_searches();
        test_unthrottled();

        await_idle();
        $display("%0d candidate transactions in %0d searches under %0d source settings",
                 offer_count, search_count, setting_count);
        $display("%0d results checked, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("display_mode_best_match regression: pass");
        else
            $display("display_mode_best_match regression: fail");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/dmbm_pkg.sv
rtl/core/dmbm_front.sv
rtl/core/dmbm_queue.sv
rtl/core/dmbm_back.sv
rtl/core/display_mode_best_match.sv
verif/display_mode_best_match_tb.sv
